// ----- rtl/core/skf_pkg.sv -----
package skf_pkg;

    // Number formats
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 32;
    localparam int VAR_BITS    = 32;
    localparam int NOISE_BITS  = 31;
    localparam int GAIN_BITS   = FRAC_BITS + 1;
    localparam int DEN_BITS    = VAR_BITS + 1;
    localparam int REM_BITS    = DEN_BITS + 1;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int CNT_BITS    = $clog2(FRAC_BITS);
    localparam int MUL_A_BITS  = (DIFF_BITS > VAR_BITS + 1) ? DIFF_BITS : VAR_BITS + 1;
    localparam int MUL_B_BITS  = GAIN_BITS + 1;
    localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << FRAC_BITS;
    localparam logic [VAR_BITS-1:0]  VAR_ONE  = VAR_BITS'(1) << FRAC_BITS;
    localparam logic [CNT_BITS-1:0]  DIV_LAST = CNT_BITS'(FRAC_BITS - 1);

    localparam logic [NOISE_BITS-1:0] PROCESS_NOISE_RESET = NOISE_BITS'(655);
    localparam logic [NOISE_BITS-1:0] MEASURE_NOISE_RESET = NOISE_BITS'(13107);

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_NOISE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEASURE_NOISE = CFG_INDEX_BITS'(1);

    // Datapath operations
    localparam int OP_BITS = 4;
    localparam logic [OP_BITS-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_BITS-1:0] OP_SEED     = 4'd2;
    localparam logic [OP_BITS-1:0] OP_ADD_Q    = 4'd3;
    localparam logic [OP_BITS-1:0] OP_DIV_INIT = 4'd4;
    localparam logic [OP_BITS-1:0] OP_DIV_STEP = 4'd5;
    localparam logic [OP_BITS-1:0] OP_SUB      = 4'd6;
    localparam logic [OP_BITS-1:0] OP_MUL_D    = 4'd7;
    localparam logic [OP_BITS-1:0] OP_ACC_X    = 4'd8;
    localparam logic [OP_BITS-1:0] OP_UPD_P    = 4'd9;
    localparam logic [OP_BITS-1:0] OP_EMIT     = 4'd10;

    // Jump conditions
    localparam int COND_BITS = 3;
    localparam logic [COND_BITS-1:0] COND_NEXT     = 3'd0;
    localparam logic [COND_BITS-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_BITS-1:0] COND_NO_INPUT = 3'd2;
    localparam logic [COND_BITS-1:0] COND_SEED     = 3'd3;
    localparam logic [COND_BITS-1:0] COND_DIV_SKIP = 3'd4;
    localparam logic [COND_BITS-1:0] COND_DIV_LOOP = 3'd5;
    localparam logic [COND_BITS-1:0] COND_OUT_BUSY = 3'd6;

    // Program addresses
    localparam int UPC_BITS = 4;
    localparam logic [UPC_BITS-1:0] ADDR_WAIT     = 4'd0;
    localparam logic [UPC_BITS-1:0] ADDR_CHECK    = 4'd1;
    localparam logic [UPC_BITS-1:0] ADDR_ADD_Q    = 4'd2;
    localparam logic [UPC_BITS-1:0] ADDR_DIV_INIT = 4'd3;
    localparam logic [UPC_BITS-1:0] ADDR_DIV_STEP = 4'd4;
    localparam logic [UPC_BITS-1:0] ADDR_SUB      = 4'd5;
    localparam logic [UPC_BITS-1:0] ADDR_MUL_D    = 4'd6;
    localparam logic [UPC_BITS-1:0] ADDR_ACC_X    = 4'd7;
    localparam logic [UPC_BITS-1:0] ADDR_UPD_P    = 4'd8;
    localparam logic [UPC_BITS-1:0] ADDR_SEED     = 4'd9;
    localparam logic [UPC_BITS-1:0] ADDR_EMIT     = 4'd10;
    localparam logic [UPC_BITS-1:0] ADDR_RETURN   = 4'd11;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [COND_BITS-1:0] cond;
        logic [UPC_BITS-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic seed;
        logic div_skip;
        logic div_more;
        logic out_busy;
    } stat_t;

    // Microcode store: one control word per program address.
    function automatic ctrl_t ucode(input logic [UPC_BITS-1:0] addr);
        ctrl_t w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, target: ADDR_WAIT};
        unique case (addr)
            ADDR_WAIT:     w = '{op: OP_LOAD,     cond: COND_NO_INPUT, target: ADDR_WAIT};
            ADDR_CHECK:    w = '{op: OP_NONE,     cond: COND_SEED,     target: ADDR_SEED};
            ADDR_ADD_Q:    w = '{op: OP_ADD_Q,    cond: COND_NEXT,     target: ADDR_WAIT};
            ADDR_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_DIV_SKIP, target: ADDR_SUB};
            ADDR_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_LOOP, target: ADDR_DIV_STEP};
            ADDR_SUB:      w = '{op: OP_SUB,      cond: COND_NEXT,     target: ADDR_WAIT};
            ADDR_MUL_D:    w = '{op: OP_MUL_D,    cond: COND_NEXT,     target: ADDR_WAIT};
            ADDR_ACC_X:    w = '{op: OP_ACC_X,    cond: COND_NEXT,     target: ADDR_WAIT};
            ADDR_UPD_P:    w = '{op: OP_UPD_P,    cond: COND_ALWAYS,   target: ADDR_EMIT};
            ADDR_SEED:     w = '{op: OP_SEED,     cond: COND_NEXT,     target: ADDR_WAIT};
            ADDR_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: ADDR_EMIT};
            ADDR_RETURN:   w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: ADDR_WAIT};
            default:       w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: ADDR_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/skf_sequencer.sv -----
module skf_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  skf_pkg::stat_t                    stat,
    output skf_pkg::ctrl_t                    ctrl,
    output logic                              at_wait
);

    logic [skf_pkg::UPC_BITS-1:0] pc_reg;
    logic [skf_pkg::UPC_BITS-1:0] pc_next;
    logic                         take_jump;

    assign ctrl    = skf_pkg::ucode(pc_reg);
    assign at_wait = (pc_reg == skf_pkg::ADDR_WAIT);

    always_comb
    begin
        unique case (ctrl.cond)
            skf_pkg::COND_NEXT:     take_jump = 1'b0;
            skf_pkg::COND_ALWAYS:   take_jump = 1'b1;
            skf_pkg::COND_NO_INPUT: take_jump = !in_valid;
            skf_pkg::COND_SEED:     take_jump = stat.seed;
            skf_pkg::COND_DIV_SKIP: take_jump = stat.div_skip;
            skf_pkg::COND_DIV_LOOP: take_jump = stat.div_more;
            skf_pkg::COND_OUT_BUSY: take_jump = stat.out_busy;
            default:                take_jump = 1'b1;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + skf_pkg::UPC_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= skf_pkg::ADDR_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/core/skf_datapath.sv -----
module skf_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  skf_pkg::ctrl_t                         ctrl,
    output skf_pkg::stat_t                         stat,
    input  logic                                   in_valid,
    input  logic signed [skf_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [skf_pkg::SAMPLE_BITS-1:0] estimate,
    output logic [skf_pkg::GAIN_BITS-1:0]          gain,
    input  logic                                   cfg_write,
    input  logic [skf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [skf_pkg::NOISE_BITS-1:0]         cfg_data
);

    logic [skf_pkg::NOISE_BITS-1:0]         pn_reg;
    logic [skf_pkg::NOISE_BITS-1:0]         mn_reg;
    logic signed [skf_pkg::SAMPLE_BITS-1:0] z_reg;
    logic                                   restart_reg;
    logic signed [skf_pkg::SAMPLE_BITS-1:0] x_reg;
    logic [skf_pkg::VAR_BITS-1:0]           var_reg;
    logic                                   started_reg;
    logic [skf_pkg::VAR_BITS-1:0]           p_reg;
    logic [skf_pkg::DEN_BITS-1:0]           den_reg;
    logic [skf_pkg::REM_BITS-1:0]           rem_reg;
    logic [skf_pkg::CNT_BITS-1:0]           cnt_reg;
    logic [skf_pkg::GAIN_BITS-1:0]          gain_reg;
    logic signed [skf_pkg::DIFF_BITS-1:0]   diff_reg;
    logic signed [skf_pkg::PROD_BITS-1:0]   mul_reg;
    logic                                   out_valid_reg;
    logic signed [skf_pkg::SAMPLE_BITS-1:0] est_out_reg;
    logic [skf_pkg::GAIN_BITS-1:0]          gain_out_reg;

    logic [skf_pkg::DEN_BITS-1:0]           var_sum;
    logic [skf_pkg::REM_BITS-1:0]           rem_shift;
    logic                                   qbit;
    logic signed [skf_pkg::MUL_A_BITS-1:0]  mul_a;
    logic signed [skf_pkg::MUL_B_BITS-1:0]  mul_b;
    logic                                   out_busy;
    logic                                   div_skip;

    assign out_busy = out_valid_reg && out_stall;
    // With no measurement noise the divisor equals the dividend (or both are
    // zero), so the gain is exactly one and the divide is skipped.
    assign div_skip = (mn_reg == '0);

    assign stat.seed     = !started_reg || restart_reg;
    assign stat.div_skip = div_skip;
    assign stat.div_more = (cnt_reg != '0);
    assign stat.out_busy = out_busy;

    assign var_sum   = {1'b0, var_reg} + skf_pkg::DEN_BITS'(pn_reg);
    assign rem_shift = {rem_reg[skf_pkg::REM_BITS-2:0], 1'b0};
    assign qbit      = (rem_shift >= skf_pkg::REM_BITS'(den_reg));

    // One shared multiplier: innovation times gain, then one-minus-gain times P.
    always_comb
    begin
        if (ctrl.op == skf_pkg::OP_ACC_X)
        begin
            mul_a = $signed(skf_pkg::MUL_A_BITS'(p_reg));
            mul_b = $signed({1'b0, skf_pkg::GAIN_ONE - gain_reg});
        end
        else
        begin
            mul_a = skf_pkg::MUL_A_BITS'(diff_reg);
            mul_b = $signed({1'b0, gain_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pn_reg        <= skf_pkg::PROCESS_NOISE_RESET;
            mn_reg        <= skf_pkg::MEASURE_NOISE_RESET;
            x_reg         <= '0;
            var_reg       <= skf_pkg::VAR_ONE;
            started_reg   <= 1'b0;
            restart_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == skf_pkg::REG_PROCESS_NOISE)
                begin
                    pn_reg <= cfg_data;
                end
                else if (cfg_index == skf_pkg::REG_MEASURE_NOISE)
                begin
                    mn_reg <= cfg_data;
                end
            end

            // A new result may be loaded in the cycle the old one transfers.
            if (ctrl.op == skf_pkg::OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (ctrl.op)
                skf_pkg::OP_LOAD:
                begin
                    if (in_valid)
                    begin
                        z_reg       <= sample;
                        restart_reg <= restart;
                    end
                end
                skf_pkg::OP_SEED:
                begin
                    x_reg       <= z_reg;
                    var_reg     <= skf_pkg::VAR_ONE;
                    started_reg <= 1'b1;
                    gain_reg    <= skf_pkg::GAIN_ONE;
                end
                skf_pkg::OP_ADD_Q:
                begin
                    p_reg <= var_sum[skf_pkg::VAR_BITS] ? '1
                                                        : var_sum[skf_pkg::VAR_BITS-1:0];
                end
                skf_pkg::OP_DIV_INIT:
                begin
                    den_reg  <= {1'b0, p_reg} + skf_pkg::DEN_BITS'(mn_reg);
                    rem_reg  <= skf_pkg::REM_BITS'(p_reg);
                    cnt_reg  <= skf_pkg::DIV_LAST;
                    gain_reg <= div_skip ? skf_pkg::GAIN_ONE : '0;
                end
                skf_pkg::OP_DIV_STEP:
                begin
                    rem_reg  <= qbit ? rem_shift - skf_pkg::REM_BITS'(den_reg) : rem_shift;
                    gain_reg <= {gain_reg[skf_pkg::GAIN_BITS-2:0], qbit};
                    cnt_reg  <= cnt_reg - skf_pkg::CNT_BITS'(1);
                end
                skf_pkg::OP_SUB:
                begin
                    diff_reg <= skf_pkg::DIFF_BITS'(z_reg) - skf_pkg::DIFF_BITS'(x_reg);
                end
                skf_pkg::OP_MUL_D:
                begin
                    mul_reg <= mul_a * mul_b;
                end
                skf_pkg::OP_ACC_X:
                begin
                    // Arithmetic shift of the product is a floor of K*(z-x).
                    x_reg   <= x_reg + mul_reg[skf_pkg::SAMPLE_BITS+skf_pkg::FRAC_BITS-1:
                                               skf_pkg::FRAC_BITS];
                    mul_reg <= mul_a * mul_b;
                end
                skf_pkg::OP_UPD_P:
                begin
                    var_reg <= mul_reg[skf_pkg::VAR_BITS+skf_pkg::FRAC_BITS-1:
                                       skf_pkg::FRAC_BITS];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == skf_pkg::OP_EMIT && !out_busy)
        begin
            est_out_reg  <= x_reg;
            gain_out_reg <= gain_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = est_out_reg;
    assign gain      = gain_out_reg;

endmodule

// ----- rtl/core/scalar_kalman_filter.sv -----
// Scalar Kalman filter (random-walk model) on signed Q16.16 samples. A new item is
// taken only after the previous one has left the program; the gain comes from a
// 16-step restoring divide, which is skipped with zero measurement noise, and a
// seeding item skips the update altogether. Reset (rst_n, asynchronous, active low)
// restores the noise registers to their defaults, clears the started flag and idles
// the sequencer.
module scalar_kalman_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input channel: a transfer happens when in_valid is high and in_stall low.
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [skf_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   restart,
    // Output channel: held in an output register until the transfer completes.
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [skf_pkg::SAMPLE_BITS-1:0] estimate,
    output logic [skf_pkg::GAIN_BITS-1:0]          gain,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [skf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [skf_pkg::NOISE_BITS-1:0]         cfg_data
);

    skf_pkg::ctrl_t ctrl;
    skf_pkg::stat_t stat;
    logic           at_wait;

    // Configuration writes go straight into the noise registers, so the port is always ready.
    assign cfg_ready = 1'b1;

    // A new sample is taken only while the program sits on its wait step; the
    // output register still lets the next sample in while a result waits.
    assign in_stall = !at_wait;

    // The sequencer walks a small microprogram: load, seed check, add process noise,
    // divide for the gain, subtract for the innovation, then the two multiplies that
    // update estimate and variance, and the output write; a seed skips to that write.
    skf_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .at_wait  (at_wait)
    );

    // The datapath holds the filter state, the noise registers, the shared
    // divider and multiplier, and the output register.
    skf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_valid  (in_valid),
        .sample    (sample),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .estimate  (estimate),
        .gain      (gain),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- verif/tb_scalar_kalman_filter.sv -----
module tb_scalar_kalman_filter;

    timeunit 1ns;
    timeprecision 1ps;

    // A short settle after the last result is enough to leave the filter idle.
    localparam int SETTLE_CYCLES  = 30;
    // A result can wait out a long receiver stall, so the watchdog only
    // fires after a long stretch in which no channel moves a transfer.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 110;

    localparam bit [63:0] ONE_Q   = 64'd1 << skf_pkg::FRAC_BITS;
    localparam bit [63:0] VAR_TOP = 64'hFFFF_FFFF;

    // Register indexes that decode to nothing; writes to them must be ignored.
    localparam logic [skf_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LOW =
        skf_pkg::CFG_INDEX_BITS'(2);
    localparam logic [skf_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_TOP = '1;

    localparam logic signed [skf_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(skf_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [skf_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(skf_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam logic [skf_pkg::NOISE_BITS-1:0]         NOISE_MAX  = '1;

    typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // One filter output: the new estimate and the gain that produced it.
    typedef struct {
        logic signed [skf_pkg::SAMPLE_BITS-1:0] estimate;
        logic [skf_pkg::GAIN_BITS-1:0]          gain;
    } filter_out_t;

    // The tracker runs its own copy of the filter. Each accepted sample is
    // pushed through the recursion and the output it must cause is queued;
    // each output transfer from the block is compared with the oldest one.
    class estimate_tracker;
        bit [skf_pkg::NOISE_BITS-1:0] process_noise;
        bit [skf_pkg::NOISE_BITS-1:0] measure_noise;
        longint                       estimate_now;
        bit [63:0]                    variance;
        bit                           started;
        filter_out_t                  awaited_outputs[$];
        int                           errors;

        function new();
            process_noise = skf_pkg::PROCESS_NOISE_RESET;
            measure_noise = skf_pkg::MEASURE_NOISE_RESET;
            estimate_now  = 0;
            variance      = ONE_Q;
            started       = 1'b0;
            errors        = 0;
        endfunction

        function void write_register(logic [skf_pkg::CFG_INDEX_BITS-1:0] index,
                                     logic [skf_pkg::NOISE_BITS-1:0] data);
            if (index == skf_pkg::REG_PROCESS_NOISE)
                process_noise = data;
            else if (index == skf_pkg::REG_MEASURE_NOISE)
                measure_noise = data;
        endfunction

        function void note_sample(logic signed [skf_pkg::SAMPLE_BITS-1:0] value,
                                  logic restart_bit);
            longint      z;
            longint      diff;
            bit [63:0]   p;
            bit [63:0]   den;
            bit [63:0]   g;
            filter_out_t res;
            z = value;
            if (!started || restart_bit)
            begin
                // A new series takes the sample as it is.
                estimate_now = z;
                variance     = ONE_Q;
                started      = 1'b1;
                g            = ONE_Q;
            end
            else
            begin
                p = variance + process_noise;
                if (p > VAR_TOP)
                    p = VAR_TOP;
                den = p + measure_noise;
                if (den == 0)
                    g = ONE_Q;
                else
                    g = (p << skf_pkg::FRAC_BITS) / den;
                if (g > ONE_Q)
                    g = ONE_Q;
                // The arithmetic shift floors the correction for either sign.
                diff         = z - estimate_now;
                estimate_now = estimate_now + ((diff * longint'(g)) >>> skf_pkg::FRAC_BITS);
                variance     = ((ONE_Q - g) * p) >> skf_pkg::FRAC_BITS;
            end
            res.estimate = estimate_now[skf_pkg::SAMPLE_BITS-1:0];
            res.gain     = g[skf_pkg::GAIN_BITS-1:0];
            awaited_outputs.insert(awaited_outputs.size(), res);
        endfunction

        function void check_output(logic signed [skf_pkg::SAMPLE_BITS-1:0] est,
                                   logic [skf_pkg::GAIN_BITS-1:0] g);
            filter_out_t exp_out;
            if (awaited_outputs.size() == 0)
            begin
                $display("%0t: output with nothing awaited: estimate %h gain %h",
                         $time, est, g);
                errors++;
                return;
            end
            exp_out = awaited_outputs.pop_front();
            if (est !== exp_out.estimate)
            begin
                $display("%0t: estimate mismatch: expected %h actual %h",
                         $time, exp_out.estimate, est);
                errors++;
            end
            if (g !== exp_out.gain)
            begin
                $display("%0t: gain mismatch: expected %h actual %h",
                         $time, exp_out.gain, g);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited_outputs.size();
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [skf_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   restart;
    logic                                   out_valid;
    logic                                   out_stall;
    logic signed [skf_pkg::SAMPLE_BITS-1:0] estimate;
    logic [skf_pkg::GAIN_BITS-1:0]          gain;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [skf_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
    logic [skf_pkg::NOISE_BITS-1:0]         cfg_data;

    estimate_tracker tracker;
    int              burst_left;
    int              idle_cycles;
    stall_mode_t     stall_mode;
    int              stall_span;

    scalar_kalman_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .estimate  (estimate),
        .gain      (gain),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // All inputs change on the falling edge. The sender works in bursts: when
    // a burst runs out it may drop valid for a random gap, then starts a new
    // burst of random length. Valid stays high through a burst, so each edge
    // sees a single assignment to it.
    task automatic put_sample(input logic signed [skf_pkg::SAMPLE_BITS-1:0] value,
                              input logic restart_bit);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= value;
        restart  <= restart_bit;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [skf_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [skf_pkg::NOISE_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops the sender and waits until every awaited output has been seen,
    // then gives the block time to settle so that a register write finds it
    // idle. The first wait is on a falling edge so that the monitor has
    // already noted the last input transfer.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.outstanding() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [skf_pkg::NOISE_BITS-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return NOISE_MAX;
            2:       return skf_pkg::NOISE_BITS'($urandom_range(0, 255));
            3:       return skf_pkg::NOISE_BITS'($urandom_range(0, 1 << 18));
            default: return skf_pkg::NOISE_BITS'($urandom);
        endcase
    endfunction

    // The receiver stalls on a pattern chosen at random from: no stall at all,
    // a fair coin, mostly stalled, or a fixed periodic pattern. This puts stalls
    // on every phase of the output.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 200);
        end
        stall_span--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
            default:     out_stall <= ((stall_span % 5) < 3);
        endcase
    end

    // Every transfer is observed on the rising edge, where inputs driven on
    // the falling edge are stable and the block's outputs still hold their
    // values from before the edge. The watchdog counts edges with no
    // transfer on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_sample(sample, restart);
            if (out_valid && !out_stall)
                tracker.check_output(estimate, gain);
            if (cfg_valid && cfg_ready)
                tracker.write_register(cfg_index, cfg_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_scalar_kalman_filter: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0]                            level;
        int unsigned                            spread;
        logic signed [skf_pkg::SAMPLE_BITS-1:0] value;
        logic                                   restart_bit;
        int unsigned                            pick;

        tracker     = new();
        burst_left  = 0;
        level       = '0;
        spread      = 1;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Reset noise settings. The very first sample seeds the series even
        // without restart, and the next two jump between the ends of the sample
        // range so the correction is as large as it gets in both signs.
        put_sample(SAMPLE_MAX, 1'b0);
        put_sample(SAMPLE_MIN, 1'b0);
        put_sample(SAMPLE_MAX, 1'b0);
        put_sample(-1, 1'b0);
        put_sample(0, 1'b1);
        put_sample(1, 1'b0);
        put_sample(SAMPLE_MIN, 1'b1);
        put_sample(SAMPLE_MAX, 1'b0);
        quiesce();

        // With no noise at all the first update drives the variance to zero,
        // and the one after it divides by zero, where the gain must be 1.0.
        write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
        write_reg(skf_pkg::REG_MEASURE_NOISE, '0);
        put_sample(32'sh0005_0000, 1'b1);
        put_sample(32'sh0064_0000, 1'b0);
        put_sample(-7, 1'b0);
        put_sample(SAMPLE_MIN, 1'b0);
        quiesce();

        // Largest noise on both registers, so the variance climbs high.
        write_reg(skf_pkg::REG_PROCESS_NOISE, NOISE_MAX);
        write_reg(skf_pkg::REG_MEASURE_NOISE, NOISE_MAX);
        put_sample(0, 1'b1);
        put_sample(SAMPLE_MAX, 1'b0);
        put_sample(SAMPLE_MIN, 1'b0);
        put_sample(SAMPLE_MAX, 1'b0);
        quiesce();

        // Huge measurement noise makes the gain tiny. Writes to indexes that
        // do not exist must leave both registers alone.
        write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
        write_reg(skf_pkg::REG_MEASURE_NOISE, NOISE_MAX);
        write_reg(REG_SPARE_LOW, skf_pkg::NOISE_BITS'(32'h1234_5678));
        write_reg(REG_SPARE_TOP, NOISE_MAX);
        put_sample(SAMPLE_MAX, 1'b1);
        put_sample(SAMPLE_MIN, 1'b0);
        put_sample(-1, 1'b0);
        put_sample(1, 1'b0);
        quiesce();

        // Random phases. Each one picks new noise settings, then feeds mostly
        // series that wander around a level with a random spread, so the
        // recursion runs long enough for the gain to settle. Some samples are
        // fully random or range extremes, and now and then a restart begins
        // a fresh series.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if ($urandom_range(0, 1))
            begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
                write_reg(skf_pkg::REG_MEASURE_NOISE, pick_noise());
            end
            else
            begin
                write_reg(skf_pkg::REG_MEASURE_NOISE, pick_noise());
                write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE_LOW + skf_pkg::CFG_INDEX_BITS'($urandom_range(0, 253)),
                          skf_pkg::NOISE_BITS'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                restart_bit = ($urandom_range(0, 15) == 0);
                if (restart_bit || $urandom_range(0, 39) == 0)
                begin
                    level  = $urandom;
                    spread = 1 << $urandom_range(0, 24);
                end
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    value = level + $urandom_range(0, 2 * spread) - spread;
                else if (pick < 17)
                    value = $urandom;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       value = SAMPLE_MIN;
                        1:       value = SAMPLE_MAX;
                        2:       value = 0;
                        default: value = -1;
                    endcase
                end
                put_sample(value, restart_bit);
            end
            quiesce();
        end

        if (tracker.errors == 0)
            $display("tb_scalar_kalman_filter: done, clean");
        else
            $display("tb_scalar_kalman_filter: done, errors");
        $finish;
    end

endmodule
